### rtl/rap_pkg.sv
package rap_pkg;

    // block geometry
    localparam int BLOCK_BYTES = 32;
    localparam int CNT_W       = $clog2(BLOCK_BYTES + 1);

    // request queue between front and back, depth a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // polynomials and block codes
    localparam logic [7:0]  DATA_POLY     = 8'h85;
    localparam logic [15:0] ADDR_POLY     = 16'h0015;
    localparam logic [15:0] BLOCK_MASK    = 16'hFFE0;
    localparam logic [15:0] ADDR_CRC_MASK = 16'h001F;
    localparam logic [15:0] MOTOR_BLOCK   = 16'hC000;
    localparam logic [15:0] PROBE_BLOCK   = 16'h8000;
    localparam logic [7:0]  PROBE_CLEAR   = 8'hFE;
    localparam logic [7:0]  PROBE_SET     = 8'h80;
    localparam logic [7:0]  MOTOR_ON      = 8'h01;
    localparam logic [7:0]  MOTOR_OFF     = 8'h00;

    // request opcodes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_PAK   = 2'd1,
        ST_ADDR_ERR = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MOTOR_KEEP  = 2'd0,
        MOTOR_STOP  = 2'd1,
        MOTOR_START = 2'd2
    } motor_cmd_t;

    // one classified request handed from front to back
    typedef struct packed {
        logic       is_read;
        status_t    status;
        logic [1:0] port;
        logic [7:0] data;
        motor_cmd_t cmd;
    } rap_cmd_t;

    // crc-8, msb first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
            begin
                c = (c << 1) ^ DATA_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    // 5-bit address check over bits 15..5
    function automatic logic address_ok(input logic [15:0] a);
        logic [15:0] rem;
        rem = a & BLOCK_MASK;
        for (int k = 15; k >= 5; k--) begin
            if (rem[k])
            begin
                rem = rem ^ (ADDR_POLY << (k - 5));
            end
        end
        return (rem & ADDR_CRC_MASK) == (a & ADDR_CRC_MASK);
    endfunction

endpackage

### rtl/rap_front.sv
module rap_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                opcode,
    input  logic [1:0]          port,
    input  logic [15:0]         pak_address,
    input  logic [7:0]          write_byte,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          accessory_port_mask,
    output logic                push,
    output rap_pkg::rap_cmd_t   push_data,
    input  logic                full
);
    import rap_pkg::*;

    logic             accept;
    logic [3:0]       mask_reg;
    logic             probe_reg;
    logic [CNT_W-1:0] wr_count_reg;
    logic [7:0]       crc_reg;
    status_t          blk_status_reg;
    motor_cmd_t       motor_reg;
    logic [1:0]       blk_port_reg;

    status_t          acc_status;
    logic             first;
    logic             wr_done;
    logic [15:0]      blk;
    motor_cmd_t       first_motor;
    status_t          cur_status;
    logic [1:0]       cur_port;
    motor_cmd_t       cur_motor;
    logic [7:0]       crc_base;
    logic [7:0]       crc_new;

    // handshakes
    assign accept    = in_valid && !full;
    assign in_stall  = full;
    assign cfg_ready = 1'b1;

    // classify the request
    always_comb
    begin
        priority if (!mask_reg[port])
        begin
            acc_status = ST_NO_PAK;
        end
        else if (!address_ok(pak_address))
        begin
            acc_status = ST_ADDR_ERR;
        end
        else
        begin
            acc_status = ST_OK;
        end
    end

    assign blk     = pak_address & BLOCK_MASK;
    assign first   = (wr_count_reg == '0);
    assign wr_done = (wr_count_reg == CNT_W'(BLOCK_BYTES - 1));

    // motor command from the first byte of a write
    always_comb
    begin
        first_motor = MOTOR_KEEP;
        if (acc_status == ST_OK && blk == MOTOR_BLOCK)
        begin
            if (write_byte == MOTOR_ON)
            begin
                first_motor = MOTOR_START;
            end
            else if (write_byte == MOTOR_OFF)
            begin
                first_motor = MOTOR_STOP;
            end
        end
    end

    // current write block view, first byte taken directly
    assign cur_status = first ? acc_status  : blk_status_reg;
    assign cur_port   = first ? port        : blk_port_reg;
    assign cur_motor  = first ? first_motor : motor_reg;
    assign crc_base   = first ? 8'h00       : crc_reg;
    assign crc_new    = crc8_step(crc_base, write_byte);

    // queue request for reads and completed writes
    assign push = accept && (opcode == OP_READ || wr_done);

    always_comb
    begin
        if (opcode == OP_READ)
        begin
            push_data.is_read = 1'b1;
            push_data.status  = acc_status;
            push_data.port    = port;
            push_data.data    = (blk == PROBE_BLOCK && probe_reg) ? PROBE_SET : 8'h00;
            push_data.cmd     = MOTOR_KEEP;
        end
        else
        begin
            push_data.is_read = 1'b0;
            push_data.status  = cur_status;
            push_data.port    = cur_port;
            push_data.data    = crc_new;
            push_data.cmd     = cur_motor;
        end
    end

    // accessory mask register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= 4'hF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mask_reg <= accessory_port_mask;
        end
    end

    // write block accumulation and probe flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg      <= 1'b0;
            wr_count_reg   <= '0;
            crc_reg        <= 8'h00;
            blk_status_reg <= ST_OK;
            motor_reg      <= MOTOR_KEEP;
            blk_port_reg   <= 2'd0;
        end
        else if (accept)
        begin
            if (opcode == OP_READ)
            begin
                wr_count_reg <= '0;
                crc_reg      <= 8'h00;
                motor_reg    <= MOTOR_KEEP;
            end
            else
            begin
                if (first)
                begin
                    blk_status_reg <= acc_status;
                    blk_port_reg   <= port;
                    if (acc_status == ST_OK && blk == PROBE_BLOCK)
                    begin
                        if (write_byte == PROBE_CLEAR)
                        begin
                            probe_reg <= 1'b0;
                        end
                        else if (write_byte == PROBE_SET)
                        begin
                            probe_reg <= 1'b1;
                        end
                    end
                end
                crc_reg      <= wr_done ? 8'h00 : crc_new;
                wr_count_reg <= wr_done ? '0 : wr_count_reg + 1'b1;
                motor_reg    <= wr_done ? MOTOR_KEEP : cur_motor;
            end
        end
    end

`ifndef SYNTHESIS
    // the byte counter stays inside the block
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_count_reg < CNT_W'(BLOCK_BYTES))
        else $error("write byte count out of range");

    // a held motor command only exists mid-block with good status
    a_motor_mid_block: assert property (@(posedge clk) disable iff (!rst_n)
        motor_reg != MOTOR_KEEP |-> wr_count_reg != '0 && blk_status_reg == ST_OK)
        else $error("motor command held outside a good write block");

    // a read always clears the write block
    a_read_drops_write: assert property (@(posedge clk) disable iff (!rst_n)
        accept && opcode == OP_READ |=> wr_count_reg == '0 && crc_reg == 8'h00)
        else $error("partial write survived a read");
`endif

endmodule

### rtl/rap_fifo.sv
module rap_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rap_pkg::rap_cmd_t   push_data,
    output logic                full,
    input  logic                pop,
    output rap_pkg::rap_cmd_t   pop_data,
    output logic                empty
);
    import rap_pkg::*;

    rap_cmd_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("request queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("request queue underflow");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("request queue level out of range");
`endif

endmodule

### rtl/rap_back.sv
module rap_back (
    input  logic                clk,
    input  logic                rst_n,
    output logic                pop,
    input  rap_pkg::rap_cmd_t   pop_data,
    input  logic                empty,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [7:0]          data_byte,
    output logic                is_crc,
    output logic                last,
    output logic [1:0]          rumble_port,
    output logic [1:0]          rumble_command
);
    import rap_pkg::*;

    logic             out_free;
    logic             busy_reg,  busy_next;
    logic [CNT_W-1:0] idx_reg,   idx_next;
    logic [7:0]       crc_reg,   crc_next;
    logic [7:0]       rd_data_reg, rd_data_next;
    logic [1:0]       rd_port_reg, rd_port_next;
    logic             out_valid_reg, out_valid_next;
    status_t          status_reg,  status_next;
    logic [7:0]       data_reg,    data_next;
    logic             is_crc_reg,  is_crc_next;
    logic             last_reg,    last_next;
    logic [1:0]       port_reg,    port_next;
    motor_cmd_t       cmd_reg,     cmd_next;

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = out_free && !busy_reg && !empty;

    // produce the next result into the output register
    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        rd_data_next   = rd_data_reg;
        rd_port_next   = rd_port_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        is_crc_next    = is_crc_reg;
        last_next      = last_reg;
        port_next      = port_reg;
        cmd_next       = cmd_reg;
        if (out_free)
        begin
            out_valid_next = 1'b0;
            if (busy_reg)
            begin
                // read block in progress
                out_valid_next = 1'b1;
                status_next    = ST_OK;
                port_next      = rd_port_reg;
                cmd_next       = MOTOR_KEEP;
                if (idx_reg == CNT_W'(BLOCK_BYTES))
                begin
                    data_next   = crc_reg;
                    is_crc_next = 1'b1;
                    last_next   = 1'b1;
                    busy_next   = 1'b0;
                end
                else
                begin
                    data_next   = rd_data_reg;
                    is_crc_next = 1'b0;
                    last_next   = 1'b0;
                    crc_next    = crc8_step(crc_reg, rd_data_reg);
                    idx_next    = idx_reg + 1'b1;
                end
            end
            else if (!empty)
            begin
                out_valid_next = 1'b1;
                port_next      = pop_data.port;
                status_next    = pop_data.status;
                if (pop_data.status != ST_OK)
                begin
                    // failed access, single result
                    data_next   = 8'h00;
                    is_crc_next = 1'b0;
                    last_next   = 1'b1;
                    cmd_next    = MOTOR_KEEP;
                end
                else if (pop_data.is_read)
                begin
                    // first data byte of a read
                    data_next    = pop_data.data;
                    is_crc_next  = 1'b0;
                    last_next    = 1'b0;
                    cmd_next     = MOTOR_KEEP;
                    busy_next    = 1'b1;
                    idx_next     = CNT_W'(1);
                    crc_next     = crc8_step(8'h00, pop_data.data);
                    rd_data_next = pop_data.data;
                    rd_port_next = pop_data.port;
                end
                else
                begin
                    // write block completion
                    data_next   = pop_data.data;
                    is_crc_next = 1'b1;
                    last_next   = 1'b1;
                    cmd_next    = pop_data.cmd;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        crc_reg     <= crc_next;
        rd_data_reg <= rd_data_next;
        rd_port_reg <= rd_port_next;
        status_reg  <= status_next;
        data_reg    <= data_next;
        is_crc_reg  <= is_crc_next;
        last_reg    <= last_next;
        port_reg    <= port_next;
        cmd_reg     <= cmd_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign data_byte      = data_reg;
    assign is_crc         = is_crc_reg;
    assign last           = last_reg;
    assign rumble_port    = port_reg;
    assign rumble_command = cmd_reg;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> idx_reg != '0 && idx_reg <= CNT_W'(BLOCK_BYTES))
        else $error("read byte index out of range");

    a_crc_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && is_crc_reg |-> last_reg && status_reg == ST_OK)
        else $error("crc result not final or not ok");

    a_motor_on_crc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && cmd_reg != MOTOR_KEEP |-> is_crc_reg && !busy_reg)
        else $error("motor command outside a write completion");
`endif

endmodule

### rtl/rumble_accessory_pak.sv
// a request is held in the request queue, then its result in the back-end output register
// write bytes are taken one per cycle unless in_stall; a write block gives one result
// a good read gives 33 results, 32 bytes then the crc, one per cycle unless stalled
// a two-entry request queue lets the front take write bytes while the back drains a read
// reset (rst_n, async, active low): probe flag and write block cleared, queue empty,
// accessory mask set to all four ports
module rumble_accessory_pak (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [1:0]  port,
    input  logic [15:0] pak_address,
    input  logic [7:0]  write_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  accessory_port_mask,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  data_byte,
    output logic        is_crc,
    output logic        last,
    output logic [1:0]  rumble_port,
    output logic [1:0]  rumble_command
);
    import rap_pkg::*;

    logic     push;
    rap_cmd_t push_data;
    logic     full;
    logic     pop;
    rap_cmd_t pop_data;
    logic     empty;

    // request classification and write accumulation
    rap_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .opcode              (opcode),
        .port                (port),
        .pak_address         (pak_address),
        .write_byte          (write_byte),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .accessory_port_mask (accessory_port_mask),
        .push                (push),
        .push_data           (push_data),
        .full                (full)
    );

    // request queue
    rap_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // result generation
    rap_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop            (pop),
        .pop_data       (pop_data),
        .empty          (empty),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .data_byte      (data_byte),
        .is_crc         (is_crc),
        .last           (last),
        .rumble_port    (rumble_port),
        .rumble_command (rumble_command)
    );

endmodule
